// ----- sv/bfse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfse_pkg
// Shared types and constants for the Brainfuck step engine.
// ----------------------------------------------------------------------------
package bfse_pkg;

    localparam int PC_W              = 13;
    localparam int LOAD_ADDR_W       = 12;
    localparam int DATA_W            = 8;
    localparam int DEF_PROGRAM_DEPTH = 4096;
    localparam int DEF_TAPE_DEPTH    = 32768;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // run status codes
    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_END = 2'd1;
    localparam logic [1:0] ST_ERR = 2'd2;

    // register index (paddr[2])
    localparam logic REG_PROGRAM_LENGTH = 1'b0;

    // command characters
    localparam logic [7:0] CH_RIGHT = 8'h3E;  // >
    localparam logic [7:0] CH_LEFT  = 8'h3C;  // <
    localparam logic [7:0] CH_INC   = 8'h2B;  // +
    localparam logic [7:0] CH_DEC   = 8'h2D;  // -
    localparam logic [7:0] CH_OUT   = 8'h2E;  // .
    localparam logic [7:0] CH_IN    = 8'h2C;  // ,
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // [
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ]

    typedef struct packed {
        logic                   opcode;
        logic [LOAD_ADDR_W-1:0] load_address;
        logic [DATA_W-1:0]      program_byte;
        logic [DATA_W-1:0]      input_byte;
    } item_t;

    typedef struct packed {
        logic              out_valid;
        logic [DATA_W-1:0] out_byte;
        logic              input_used;
        logic [1:0]        run_status;
        logic [PC_W-1:0]   next_counter;
    } result_t;

endpackage

// ----- sv/brainfuck_step_engine_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_step_engine_top
// Brainfuck step engine: program RAM, cell tape RAM, step sequencer, APB regs.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each transaction
// gives exactly one result, shown on result for one cycle with done high; the
// receiver cannot stall it. After reset the tape RAM is cleared one cell per
// cycle, and busy stays high until the last cell is written (configuration
// writes still work then). A load transaction, or a step taken while halted
// or at program end, completes at the accept edge: done rises the next cycle
// and busy never goes high, so these run one per cycle. An executed step
// issues the command fetch and the cell read to the two RAMs in the accept
// cycle; the next cycle executes and writes the cell back. A bracket that
// jumps then moves to a scan, which reads the program RAM one address per
// cycle until it finds the partner bracket or runs out of program.
// ----------------------------------------------------------------------------
module brainfuck_step_engine_top
    import bfse_pkg::*;
#(
    parameter int PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
    parameter int TAPE_DEPTH    = DEF_TAPE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    // command channel
    input  logic        start,
    input  item_t       item,
    output logic        busy,
    output logic        done,
    output result_t     result,

    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PAW = $clog2(PROGRAM_DEPTH);
    localparam int TAW = $clog2(TAPE_DEPTH);

    // program_length register, low PC_W bits of the value as written
    logic [PC_W-1:0]   len_reg;
    logic [PC_W-1:0]   prog_len;
    logic [31:0]       len_sat;
    logic              cfg_wr;

    logic              prog_we;
    logic [PAW-1:0]    prog_waddr;
    logic [DATA_W-1:0] prog_wdata;
    logic [PAW-1:0]    prog_raddr;
    logic [DATA_W-1:0] prog_rdata;

    logic              tape_we;
    logic [TAW-1:0]    tape_waddr;
    logic [DATA_W-1:0] tape_wdata;
    logic [TAW-1:0]    tape_raddr;
    logic [DATA_W-1:0] tape_rdata;

    // APB: zero wait states; one register at word 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_PROGRAM_LENGTH))
        begin
            len_reg <= pwdata[PC_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_PROGRAM_LENGTH)
        begin
            prdata = 32'(len_reg);
        end
    end

    // lengths beyond the program RAM saturate to its depth
    assign len_sat  = (32'(len_reg) > 32'(PROGRAM_DEPTH)) ? 32'(PROGRAM_DEPTH)
                                                          : 32'(len_reg);
    assign prog_len = len_sat[PC_W-1:0];

    bfse_ram #(
        .DEPTH (PROGRAM_DEPTH),
        .WIDTH (DATA_W)
    ) u_prog_ram (
        .clk   (clk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (prog_wdata),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    bfse_ram #(
        .DEPTH (TAPE_DEPTH),
        .WIDTH (DATA_W)
    ) u_tape_ram (
        .clk   (clk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (tape_raddr),
        .rdata (tape_rdata)
    );

    bfse_seq #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .TAPE_DEPTH    (TAPE_DEPTH)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .prog_len   (prog_len),
        .busy       (busy),
        .done       (done),
        .result     (result),
        .prog_we    (prog_we),
        .prog_waddr (prog_waddr),
        .prog_wdata (prog_wdata),
        .prog_raddr (prog_raddr),
        .prog_rdata (prog_rdata),
        .tape_we    (tape_we),
        .tape_waddr (tape_waddr),
        .tape_wdata (tape_wdata),
        .tape_raddr (tape_raddr),
        .tape_rdata (tape_rdata)
    );

endmodule

// ----- sv/bfse_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfse_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfse_ram
    import bfse_pkg::*;
#(
    parameter int  DEPTH = DEF_PROGRAM_DEPTH,
    parameter int  WIDTH = DATA_W,
    localparam int AW    = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/bfse_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfse_seq
// Step sequencer: tape clear, fetch/execute, bracket scan over program RAM.
// ----------------------------------------------------------------------------
module bfse_seq
    import bfse_pkg::*;
#(
    parameter int  PROGRAM_DEPTH = DEF_PROGRAM_DEPTH,
    parameter int  TAPE_DEPTH    = DEF_TAPE_DEPTH,
    localparam int PAW           = $clog2(PROGRAM_DEPTH),
    localparam int TAW           = $clog2(TAPE_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  item_t             item,
    input  logic [PC_W-1:0]   prog_len,
    output logic              busy,
    output logic              done,
    output result_t           result,
    output logic              prog_we,
    output logic [PAW-1:0]    prog_waddr,
    output logic [DATA_W-1:0] prog_wdata,
    output logic [PAW-1:0]    prog_raddr,
    input  logic [DATA_W-1:0] prog_rdata,
    output logic              tape_we,
    output logic [TAW-1:0]    tape_waddr,
    output logic [DATA_W-1:0] tape_wdata,
    output logic [TAW-1:0]    tape_raddr,
    input  logic [DATA_W-1:0] tape_rdata
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_SCAN  = 4'b1000
    } state_t;

    localparam logic [TAW-1:0] PTR_LAST = TAW'(TAPE_DEPTH - 1);

    state_t            state_reg, state_next;
    logic [PC_W-1:0]   pc_reg, pc_next;
    logic [TAW-1:0]    ptr_reg, ptr_next;
    logic [1:0]        status_reg, status_next;
    logic [TAW-1:0]    clr_reg, clr_next;
    logic [PC_W-1:0]   j_reg, j_next;
    logic [PC_W-1:0]   depth_reg, depth_next;
    logic              back_reg, back_next;
    logic [DATA_W-1:0] ibyte_reg, ibyte_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic              accept;
    logic [PC_W-1:0]   rd_pc;
    logic [31:0]       waddr_ext;
    logic [31:0]       raddr_ext;
    logic [PC_W-1:0]   pc_inc;
    logic [PC_W-1:0]   j_inc;
    logic [PC_W-1:0]   j_dec;

    // finishing transaction
    logic              fin;
    logic [PC_W-1:0]   f_pc;
    logic [1:0]        f_st;
    logic              f_ov;
    logic [DATA_W-1:0] f_ob;
    logic              f_iu;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && (state_reg == S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // program loads go straight to the RAM at the accept edge
    assign waddr_ext  = 32'(item.load_address);
    assign prog_we    = accept && (item.opcode == OP_LOAD)
                        && (waddr_ext < 32'(PROGRAM_DEPTH));
    assign prog_waddr = waddr_ext[PAW-1:0];
    assign prog_wdata = item.program_byte;

    assign raddr_ext  = 32'(rd_pc);
    assign prog_raddr = raddr_ext[PAW-1:0];
    assign tape_raddr = ptr_reg;

    assign pc_inc = pc_reg + PC_W'(1);
    assign j_inc  = j_reg + PC_W'(1);
    assign j_dec  = j_reg - PC_W'(1);

    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        ptr_next    = ptr_reg;
        status_next = status_reg;
        clr_next    = clr_reg;
        j_next      = j_reg;
        depth_next  = depth_reg;
        back_next   = back_reg;
        ibyte_next  = ibyte_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_pc       = pc_reg;
        tape_we     = 1'b0;
        tape_waddr  = ptr_reg;
        tape_wdata  = '0;
        fin         = 1'b0;
        f_pc        = pc_reg;
        f_st        = status_reg;
        f_ov        = 1'b0;
        f_ob        = '0;
        f_iu        = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                if (clr_reg == PTR_LAST)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + TAW'(1);
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    ibyte_next = item.input_byte;
                    if ((item.opcode == OP_LOAD) || (status_reg != ST_RUN))
                    begin
                        fin = 1'b1;
                    end
                    else if (pc_reg >= prog_len)
                    begin
                        fin  = 1'b1;
                        f_st = ST_END;
                    end
                    else
                    begin
                        // command and cell reads were issued this cycle
                        state_next = S_EXEC;
                    end
                end
            end

            S_EXEC:
            begin
                fin  = 1'b1;
                f_pc = pc_inc;
                case (prog_rdata)
                    CH_RIGHT:
                    begin
                        ptr_next = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + TAW'(1);
                    end
                    CH_LEFT:
                    begin
                        ptr_next = (ptr_reg == '0) ? PTR_LAST : ptr_reg - TAW'(1);
                    end
                    CH_INC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata + 8'd1;
                    end
                    CH_DEC:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = tape_rdata - 8'd1;
                    end
                    CH_OUT:
                    begin
                        f_ov = 1'b1;
                        f_ob = tape_rdata;
                    end
                    CH_IN:
                    begin
                        tape_we    = 1'b1;
                        tape_wdata = ibyte_reg;
                        f_iu       = 1'b1;
                    end
                    CH_OPEN:
                    begin
                        if (tape_rdata == '0)
                        begin
                            if (pc_inc >= prog_len)
                            begin
                                f_st = ST_ERR;
                                f_pc = pc_reg;
                            end
                            else
                            begin
                                fin        = 1'b0;
                                rd_pc      = pc_inc;
                                j_next     = pc_inc;
                                depth_next = PC_W'(1);
                                back_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (tape_rdata != '0)
                        begin
                            if (pc_reg == '0)
                            begin
                                f_st = ST_ERR;
                                f_pc = pc_reg;
                            end
                            else
                            begin
                                fin        = 1'b0;
                                rd_pc      = pc_reg - PC_W'(1);
                                j_next     = pc_reg - PC_W'(1);
                                depth_next = PC_W'(1);
                                back_next  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_SCAN:
            begin
                // prog_rdata holds the byte at j_reg; next address issued each cycle
                if (!back_reg)
                begin
                    if (prog_rdata == CH_OPEN)
                    begin
                        depth_next = depth_reg + PC_W'(1);
                    end
                    else if (prog_rdata == CH_CLOSE)
                    begin
                        depth_next = depth_reg - PC_W'(1);
                    end

                    if ((prog_rdata == CH_CLOSE) && (depth_reg == PC_W'(1)))
                    begin
                        fin  = 1'b1;
                        f_pc = j_inc;
                    end
                    else if (j_inc >= prog_len)
                    begin
                        fin  = 1'b1;
                        f_st = ST_ERR;
                    end
                    else
                    begin
                        rd_pc  = j_inc;
                        j_next = j_inc;
                    end
                end
                else
                begin
                    if (prog_rdata == CH_CLOSE)
                    begin
                        depth_next = depth_reg + PC_W'(1);
                    end
                    else if (prog_rdata == CH_OPEN)
                    begin
                        depth_next = depth_reg - PC_W'(1);
                    end

                    if ((prog_rdata == CH_OPEN) && (depth_reg == PC_W'(1)))
                    begin
                        fin  = 1'b1;
                        f_pc = j_inc;
                    end
                    else if (j_reg == '0)
                    begin
                        fin  = 1'b1;
                        f_st = ST_ERR;
                    end
                    else
                    begin
                        rd_pc  = j_dec;
                        j_next = j_dec;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // end of program reached by an executed step
        if (fin && ((state_reg == S_EXEC) || (state_reg == S_SCAN))
            && (f_st == ST_RUN) && (f_pc >= prog_len))
        begin
            f_st = ST_END;
        end

        if (fin)
        begin
            pc_next                  = f_pc;
            status_next              = f_st;
            done_next                = 1'b1;
            state_next               = S_IDLE;
            result_next.out_valid    = f_ov;
            result_next.out_byte     = f_ob;
            result_next.input_used   = f_iu;
            result_next.run_status   = f_st;
            result_next.next_counter = f_pc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            pc_reg     <= '0;
            ptr_reg    <= '0;
            status_reg <= ST_RUN;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            ptr_reg    <= ptr_next;
            status_reg <= status_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        depth_reg  <= depth_next;
        back_reg   <= back_next;
        ibyte_reg  <= ibyte_next;
        result_reg <= result_next;
    end

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while a transaction is still in progress");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg != ST_RUN) |=> $stable(status_reg))
        else $error("halt status changed after halting");

    a_scan_no_tape_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !tape_we)
        else $error("tape written during bracket scan");

    a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (!done_reg && !prog_we))
        else $error("activity during tape clear");

    a_exec_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> ($past(state_reg) == S_IDLE && status_reg == ST_RUN))
        else $error("execute entered without an accepted step");
`endif

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for brainfuck_step_engine_top. A behavioral copy of the
// engine predicts every result. The bench loads programs through load
// transactions, runs them one command per step transaction and scores each
// done strobe against the expected result, field by field. Configuration goes
// through the APB port. The run ends by forcing an unmatched bracket and then
// checking that the halt holds.
// ----------------------------------------------------------------------------
module tb;
    import bfse_pkg::*;

    // The clear pass after reset must fit within the watchdog limit.
    localparam int WATCHDOG_LIMIT = 4 * DEF_TAPE_DEPTH;
    localparam int ITEMS_PER_PHASE = 325;
    localparam int FRONTIER_CAP   = 3600;

    // APB byte addresses: register index sits in paddr[2]
    localparam logic [2:0] ADDR_PROGRAM_LENGTH = {REG_PROGRAM_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED       = {~REG_PROGRAM_LENGTH, 2'b00};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    item_t       item = '0;
    logic        busy;
    logic        done;
    result_t     result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    brainfuck_step_engine_top uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .busy    (busy),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Engine shadow state. Updated at the edge where a transaction is taken.
    // ------------------------------------------------------------------------
    bit   [7:0]                         program_mem [DEF_PROGRAM_DEPTH];
    bit   [7:0]                         tape_mem    [DEF_TAPE_DEPTH];
    logic [PC_W-1:0]                    prog_ctr = '0;
    logic [$clog2(DEF_TAPE_DEPTH)-1:0]  cell_ptr = '0;   // power-of-two tape, wraps itself
    logic [1:0]                         run_state = ST_RUN;
    logic [PC_W-1:0]                    length_reg = '0;

    result_t pending_results [$];   // one entry per accepted transaction, oldest first

    // Program layout: directed code from 0, then random fragments appended back
    // to back. Everything below frontier is loaded, so no scan touches an
    // unwritten byte.
    int unsigned frontier = 0;
    int unsigned frag_base = 0;
    int unsigned frag_steps = 0;
    int unsigned frag_budget = 0;

    int unsigned idle_pct = 0;
    int unsigned fail_count = 0;
    int unsigned items_sent = 0;
    int unsigned n_steps = 0;
    int unsigned n_emitted = 0;
    int unsigned n_fragments = 0;
    int unsigned n_cut = 0;
    int unsigned stall_cycles = 0;

    // Exercises both pointer wraps, cell wrap, '[' skip, ']' jump back, a
    // non-command byte and every command.
    logic [7:0] demo_program [$] = '{CH_LEFT, CH_DEC, CH_OUT, CH_RIGHT, CH_OPEN,
                                     CH_CLOSE, CH_IN, CH_OPEN, CH_DEC, CH_CLOSE,
                                     8'hFF, CH_INC, CH_OUT};

    // shadow program store lookup, address below the store depth
    function automatic logic [7:0] prog_byte_at(input int unsigned a);
        return program_mem[a[LOAD_ADDR_W-1:0]];
    endfunction

    // ------------------------------------------------------------------------
    // Prediction: one transaction in, one result out.
    // ------------------------------------------------------------------------
    function automatic result_t execute_item(input item_t it);
        result_t         r;
        int unsigned     lim;
        int unsigned     j;
        int              depth;
        bit              hit;
        logic [PC_W-1:0] nxt;
        r   = '0;
        lim = 32'(length_reg);
        if (lim > DEF_PROGRAM_DEPTH)
            lim = DEF_PROGRAM_DEPTH;
        if (it.opcode == OP_LOAD)
        begin
            program_mem[it.load_address] = it.program_byte;
        end
        else if (run_state == ST_RUN)
        begin
            if (prog_ctr < lim)
            begin
                nxt = prog_ctr + 1'b1;
                case (prog_byte_at(32'(prog_ctr)))
                    CH_RIGHT: cell_ptr = cell_ptr + 1'b1;
                    CH_LEFT:  cell_ptr = cell_ptr - 1'b1;
                    CH_INC:   tape_mem[cell_ptr] = tape_mem[cell_ptr] + 8'd1;
                    CH_DEC:   tape_mem[cell_ptr] = tape_mem[cell_ptr] - 8'd1;
                    CH_OUT:
                    begin
                        r.out_valid = 1'b1;
                        r.out_byte  = tape_mem[cell_ptr];
                    end
                    CH_IN:
                    begin
                        tape_mem[cell_ptr] = it.input_byte;
                        r.input_used       = 1'b1;
                    end
                    CH_OPEN:
                    begin
                        if (tape_mem[cell_ptr] == 8'd0)
                        begin
                            // forward scan, stops at the partner or at length
                            depth = 1;
                            j     = 32'(prog_ctr) + 1;
                            hit   = 1'b0;
                            while (j < lim && !hit)
                            begin
                                if (prog_byte_at(j) == CH_OPEN)
                                    depth++;
                                else if (prog_byte_at(j) == CH_CLOSE)
                                    depth--;
                                if (depth == 0)
                                    hit = 1'b1;
                                else
                                    j++;
                            end
                            if (hit)
                                nxt = PC_W'(j + 1);
                            else
                            begin
                                run_state = ST_ERR;
                                nxt       = prog_ctr;
                            end
                        end
                    end
                    CH_CLOSE:
                    begin
                        if (tape_mem[cell_ptr] != 8'd0)
                        begin
                            // backward scan toward address 0
                            depth = 1;
                            j     = 32'(prog_ctr);
                            hit   = 1'b0;
                            while (j > 0 && !hit)
                            begin
                                j--;
                                if (prog_byte_at(j) == CH_CLOSE)
                                    depth++;
                                else if (prog_byte_at(j) == CH_OPEN)
                                    depth--;
                                hit = (depth == 0);
                            end
                            if (hit)
                                nxt = PC_W'(j + 1);
                            else
                            begin
                                run_state = ST_ERR;
                                nxt       = prog_ctr;
                            end
                        end
                    end
                    default: ;
                endcase
                prog_ctr = nxt;
            end
            if (run_state == ST_RUN && prog_ctr >= lim)
                run_state = ST_END;
        end
        r.run_status   = run_state;
        r.next_counter = prog_ctr;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Scoring
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // done is sampled at the edge that ends its cycle
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: result with nothing pending, expected none, got %p",
                         $time, result);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("out_valid", 32'(want.out_valid), 32'(result.out_valid));
                check_field("out_byte", 32'(want.out_byte), 32'(result.out_byte));
                check_field("input_used", 32'(want.input_used), 32'(result.input_used));
                check_field("run_status", 32'(want.run_status), 32'(result.run_status));
                check_field("next_counter", 32'(want.next_counter),
                            32'(result.next_counter));
            end
        end
    end

    // Cycles with no transaction in either direction; the clear pass after
    // reset is the longest legal stretch.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Command channel
    // ------------------------------------------------------------------------
    // Leaves start high on return so back-to-back transactions need no second
    // assignment in the same step; anything else must go through drain_results.
    task automatic send_item(input item_t it);
        result_t r;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy !== 1'b0);
        r = execute_item(it);
        pending_results.push_back(r);
        items_sent++;
        if (r.out_valid)
            n_emitted++;
    endtask

    task automatic load_byte(input logic [LOAD_ADDR_W-1:0] addr, input logic [7:0] b);
        item_t it;
        it.opcode       = OP_LOAD;
        it.load_address = addr;
        it.program_byte = b;
        it.input_byte   = 8'($urandom_range(0, 255));
        send_item(it);
    endtask

    task automatic step_engine(input logic [7:0] in_byte);
        item_t it;
        it.opcode       = OP_STEP;
        it.load_address = LOAD_ADDR_W'($urandom_range(0, DEF_PROGRAM_DEPTH - 1));
        it.program_byte = 8'($urandom_range(0, 255));
        it.input_byte   = in_byte;
        send_item(it);
        n_steps++;
        frag_steps++;
    endtask

    // Quiet point: stop sending and wait out every pending result.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // APB port: setup, access, then an idle cycle
    // ------------------------------------------------------------------------
    task automatic apb_transfer(input bit wr, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (wr && addr == ADDR_PROGRAM_LENGTH)
            length_reg = wdata[PC_W-1:0];
        @(posedge clk);
    endtask

    task automatic check_length();
        logic [31:0] got;
        apb_transfer(1'b0, ADDR_PROGRAM_LENGTH, '0, got);
        check_field("program_length", 32'(length_reg), 32'(got[PC_W-1:0]));
    endtask

    task automatic set_length(input logic [31:0] value);
        logic [31:0] unused;
        apb_transfer(1'b1, ADDR_PROGRAM_LENGTH, value, unused);
        check_length();
    endtask

    // ------------------------------------------------------------------------
    // Program generation
    // ------------------------------------------------------------------------
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_RIGHT || b == CH_LEFT || b == CH_INC || b == CH_DEC ||
               b == CH_OUT || b == CH_IN || b == CH_OPEN || b == CH_CLOSE);
        return b;
    endfunction

    function automatic logic [7:0] pick_plain();
        int unsigned pick;
        logic [7:0]  b;
        pick = $urandom_range(0, 99);
        if (pick < 20)      b = CH_INC;
        else if (pick < 36) b = CH_DEC;
        else if (pick < 48) b = CH_RIGHT;
        else if (pick < 60) b = CH_LEFT;
        else if (pick < 75) b = CH_OUT;
        else if (pick < 87) b = CH_IN;
        else                b = noise_byte();
        return b;
    endfunction

    // Balanced fragment at the frontier; nesting kept shallow.
    task automatic append_fragment();
        int unsigned n;
        int unsigned depth;
        int unsigned pick;
        logic [7:0]  body [$];
        n     = $urandom_range(4, 20);
        depth = 0;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 12 && depth < 3)
            begin
                body.push_back(CH_OPEN);
                depth++;
            end
            else if (pick < 26 && depth > 0)
            begin
                body.push_back(CH_CLOSE);
                depth--;
            end
            else
                body.push_back(pick_plain());
        end
        while (depth > 0)
        begin
            body.push_back(CH_CLOSE);
            depth--;
        end
        frag_base   = frontier;
        frag_steps  = 0;
        frag_budget = 8 * body.size() + 40;
        n_fragments++;
        foreach (body[i])
            load_byte(LOAD_ADDR_W'(frontier + i), body[i]);
        frontier += body.size();
    endtask

    // Runaway loop: overwrite every bracket of the current fragment with a
    // no-op. Pairs go together, so the rest of the program stays balanced.
    task automatic cut_loops();
        for (int a = frag_base; a < frontier; a++)
        begin
            if (prog_byte_at(a) == CH_OPEN || prog_byte_at(a) == CH_CLOSE)
                load_byte(LOAD_ADDR_W'(a), noise_byte());
        end
        frag_steps = 0;
        n_cut++;
    endtask

    // One move of the random driver: extend, unstick, scribble past the
    // frontier now and then, otherwise step.
    task automatic advance_program();
        if (prog_ctr == frontier)
            append_fragment();
        else if (frag_steps > frag_budget)
            cut_loops();
        else if ($urandom_range(0, 99) < 5)
            load_byte(LOAD_ADDR_W'($urandom_range(frontier, DEF_PROGRAM_DEPTH - 1)),
                      8'($urandom_range(0, 255)));
        else
            step_engine(8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset value, write to an unmapped index, low extreme of the length.
    task automatic test_register_access();
        logic [31:0] unused;
        check_length();
        apb_transfer(1'b1, ADDR_UNMAPPED, $urandom(), unused);
        check_length();
        set_length('0);
    endtask

    task automatic test_directed_program();
        idle_pct = 0;
        foreach (demo_program[i])
            load_byte(LOAD_ADDR_W'(i), demo_program[i]);
        load_byte(LOAD_ADDR_W'(DEF_PROGRAM_DEPTH - 1), 8'h00);
        frontier = demo_program.size();
        // length above the store size saturates
        drain_results();
        set_length(32'hFFFF_FFFF);
        while (prog_ctr != frontier)
            step_engine(8'h02);
    endtask

    // Four phases, each with its own length setting; the sender idles in the middle two.
    task automatic test_random_programs();
        int unsigned idle_plan [4] = '{0, 87, 23, 0};
        int unsigned first;
        logic [31:0] unused;
        for (int p = 0; p < 4; p++)
        begin
            drain_results();
            case (p)
                0: set_length(DEF_PROGRAM_DEPTH);
                1:
                begin
                    set_length(DEF_PROGRAM_DEPTH - 1);
                    apb_transfer(1'b1, ADDR_UNMAPPED, $urandom(), unused);
                    check_length();
                end
                2: set_length($urandom_range(DEF_PROGRAM_DEPTH + 1, (1 << PC_W) - 2));
                default: set_length(($urandom() & ~((32'd1 << PC_W) - 1)) |
                                    $urandom_range(FRONTIER_CAP + 64, (1 << PC_W) - 1));
            endcase
            idle_pct = idle_plan[p];
            first    = items_sent;
            while (items_sent - first < ITEMS_PER_PHASE && frontier < FRONTIER_CAP)
                advance_program();
        end
    endtask

    // Finish the current fragment, then ',' with a nonzero byte and a lone
    // ']': the backward scan walks the whole program and finds no partner.
    // After that the halt must hold for steps, and loads still complete.
    task automatic test_unmatched_bracket();
        idle_pct = 23;
        while (prog_ctr != frontier)
            advance_program();
        load_byte(LOAD_ADDR_W'(frontier), CH_IN);
        load_byte(LOAD_ADDR_W'(frontier + 1), CH_CLOSE);
        frontier += 2;
        step_engine(8'($urandom_range(1, 255)));
        step_engine(8'($urandom_range(0, 255)));
        repeat (6)
        begin
            if ($urandom_range(0, 1))
                step_engine(8'($urandom_range(0, 255)));
            else
                load_byte(LOAD_ADDR_W'($urandom_range(0, DEF_PROGRAM_DEPTH - 1)),
                          8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_directed_program();
        test_random_programs();
        test_unmatched_bracket();

        drain_results();
        repeat (64) @(posedge clk);

        $display("Ran %0d transactions: %0d steps, %0d output bytes, %0d fragments,",
                 items_sent, n_steps, n_emitted, n_fragments);
        $display("%0d runaway loops cut, final status %0d at counter %0d",
                 n_cut, run_state, prog_ctr);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- brainfuck_step_engine_top.f -----
sv/bfse_pkg.sv
sv/bfse_ram.sv
sv/bfse_seq.sv
sv/brainfuck_step_engine_top.sv
bench/tb.sv
